>>> rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;
   localparam int COLUMNS = 80;
   localparam int ROWS = 25;
   localparam int CELLS = COLUMNS * ROWS;
   localparam int COL_W = 7;
   localparam int ROW_W = 5;
   localparam int ADDR_W = 11;
   localparam int OFS_W = 11;
   localparam int QDEPTH = 2;

   localparam logic [1:0] KIND_PUT = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_SETCUR = 2'd2;
   localparam logic [1:0] KIND_READ = 2'd3;

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_RETURN = 8'd13;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB = 8'd9;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [2:0] TAB_SPACES = 3'd4;

   typedef enum logic [2:0] {
      OP_PRINT = 3'd0, OP_NEWLINE = 3'd1, OP_RETURN = 3'd2, OP_BACK = 3'd3,
      OP_CLEAR = 3'd4, OP_SETCUR = 3'd5, OP_READ = 3'd6
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [2:0]        reps;
      logic [7:0]        ch;
      logic [7:0]        attr;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
   } cmd_type;
endpackage

>>> rtl/text_console_writer.sv
// Top level of the text console writer.
`timescale 1ns / 1ps
// Text console of 80x25 cells with a cursor.
// req channel: one command per transaction (put char, clear, set cursor, read cell).
// rsp channel: one result per command with cursor, offset and read cell data.
// A two-entry queue decouples request decode from the execution sequencer,
// which owns the single-port cell memory.
// A character prints one cell and a tab prints four spaces, each advancing
// the cursor; printing into the last cell of the bottom row, or a newline
// on the bottom row, scrolls: every row moves up by one and the last row is
// filled with spaces. A clear fills every cell with spaces. The sequencer
// handles one command at a time.
// After reset a clearing pass zeroes the memory; requests queue up (two
// deep) but execute only after it.
// When rsp_tready is low the result holds in its register; the sequencer
// finishes the next command and then waits, and the front keeps filling
// the queue until full.
module text_console_writer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // kind[1:0] ch[9:2] fg[13:10] bg[17:14] col[24:18] row[29:25]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // cursor_col, cursor_row, cursor_offset, cell_char, cell_attr
);
   logic q_valid, q_ready;
   tcw_pkg::cmd_type q_cmd;

   tcw_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata(req_tdata[29:0]),
      .q_valid, .q_ready, .q_cmd
   );

   tcw_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_cmd, .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under stall");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6:0] < 7'(tcw_pkg::COLUMNS)
                  && rsp_tdata[11:7] < 5'(tcw_pkg::ROWS))
      else $error("cursor out of grid");
`endif
endmodule

>>> rtl/tcw_front.sv
// Front end: accepts requests, classifies them and saturates coordinates.
`timescale 1ns / 1ps
module tcw_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [29:0]       req_tdata,
   output logic              q_valid,
   input  logic              q_ready,
   output tcw_pkg::cmd_type  q_cmd
);
   tcw_pkg::cmd_type q_ff [tcw_pkg::QDEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, wr_ff;
   tcw_pkg::cmd_type c;
   logic [1:0] kind;
   logic [7:0] ch;
   logic [6:0] icol;
   logic [4:0] irow;

   assign kind = req_tdata[1:0];
   assign ch = req_tdata[9:2];
   assign icol = req_tdata[24:18];
   assign irow = req_tdata[29:25];

   always_comb begin
      c.ch = ch;
      c.attr = {req_tdata[17:14], req_tdata[13:10]};
      c.col = (icol > 7'(tcw_pkg::COLUMNS - 1)) ? 7'(tcw_pkg::COLUMNS - 1) : icol;
      c.row = (irow > 5'(tcw_pkg::ROWS - 1)) ? 5'(tcw_pkg::ROWS - 1) : irow;
      c.reps = 3'd1;
      case (kind)
         tcw_pkg::KIND_PUT: begin
            if (ch == tcw_pkg::CH_NEWLINE) c.op = tcw_pkg::OP_NEWLINE;
            else if (ch == tcw_pkg::CH_RETURN) c.op = tcw_pkg::OP_RETURN;
            else if (ch == tcw_pkg::CH_BACKSPACE) c.op = tcw_pkg::OP_BACK;
            else if (ch == tcw_pkg::CH_TAB) begin
               c.op = tcw_pkg::OP_PRINT;
               c.ch = tcw_pkg::CH_SPACE;
               c.reps = tcw_pkg::TAB_SPACES;
            end else c.op = tcw_pkg::OP_PRINT;
         end
         tcw_pkg::KIND_CLEAR:  c.op = tcw_pkg::OP_CLEAR;
         tcw_pkg::KIND_SETCUR: c.op = tcw_pkg::OP_SETCUR;
         default:              c.op = tcw_pkg::OP_READ;
      endcase
   end

   logic push, pop;
   assign req_tready = cnt_ff != 2'(tcw_pkg::QDEPTH);
   assign push = req_tvalid && req_tready;
   assign q_valid = cnt_ff != 2'd0;
   assign pop = q_valid && q_ready;
   assign q_cmd = q_ff[rd_ff];
   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
      end
      if (push) q_ff[wr_ff] <= c;
   end
endmodule

>>> rtl/tcw_back.sv
// Back end: sequencer that owns the cell memory and the cursor.
`timescale 1ns / 1ps
module tcw_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  tcw_pkg::cmd_type  q_cmd,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata
);
   localparam int AW = tcw_pkg::ADDR_W;
   localparam logic [AW-1:0] LAST = AW'(tcw_pkg::CELLS - 1);
   localparam logic [AW-1:0] SHIFT_END = AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);

   typedef enum logic [7:0] {
      S_INIT = 8'b00000001, S_IDLE = 8'b00000010, S_EXEC = 8'b00000100,
      S_SCRD = 8'b00001000, S_SCWR = 8'b00010000, S_FILL = 8'b00100000,
      S_RDWT = 8'b01000000, S_DONE = 8'b10000000
   } state_type;

   logic [15:0] mem [tcw_pkg::CELLS];
   logic [15:0] rdata_ff;
   state_type st_ff, st_in;
   tcw_pkg::cmd_type cmd_ff;
   logic [6:0] col_ff, col_in;
   logic [4:0] row_ff, row_in;
   logic [AW-1:0] rowbase_ff, rowbase_in, ptr_ff, ptr_in, end_ff, end_in;
   logic [2:0] reps_ff, reps_in;
   logic [7:0] attr_ff;
   logic we, re, load;
   logic [AW-1:0] waddr, raddr;
   logic [15:0] wdata;
   logic rsp_v_ff, rsp_v_in, cap;
   logic [15:0] cell_ff;

   assign q_ready = (st_ff == S_IDLE);
   assign load = q_valid && q_ready;

   always_comb begin
      st_in = st_ff; col_in = col_ff; row_in = row_ff; rowbase_in = rowbase_ff;
      ptr_in = ptr_ff; end_in = end_ff; reps_in = reps_ff;
      we = 1'b0; re = 1'b0; waddr = ptr_ff; raddr = ptr_ff;
      wdata = {attr_ff, tcw_pkg::CH_SPACE};
      rsp_v_in = rsp_v_ff && !rsp_tready; cap = 1'b0;
      case (st_ff)
         S_INIT: begin
            we = 1'b1; wdata = 16'd0; ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == LAST) st_in = S_IDLE;
         end
         S_IDLE: if (load) begin
            st_in = S_EXEC; reps_in = q_cmd.reps;
         end
         S_EXEC: begin
            case (cmd_ff.op)
               tcw_pkg::OP_PRINT: begin
                  we = 1'b1; waddr = rowbase_ff + AW'(col_ff);
                  wdata = {cmd_ff.attr, cmd_ff.ch};
                  reps_in = reps_ff - 1'b1;
                  if (col_ff == 7'(tcw_pkg::COLUMNS - 1)) begin
                     col_in = 7'd0;
                     if (row_ff == 5'(tcw_pkg::ROWS - 1)) begin
                        ptr_in = '0; st_in = S_SCRD;
                     end else begin
                        row_in = row_ff + 1'b1;
                        rowbase_in = rowbase_ff + AW'(tcw_pkg::COLUMNS);
                        if (reps_ff == 3'd1) st_in = S_DONE;
                     end
                  end else begin
                     col_in = col_ff + 1'b1;
                     if (reps_ff == 3'd1) st_in = S_DONE;
                  end
               end
               tcw_pkg::OP_NEWLINE: begin
                  if (row_ff == 5'(tcw_pkg::ROWS - 1)) begin
                     ptr_in = '0; st_in = S_SCRD; reps_in = 3'd1;
                  end else begin
                     row_in = row_ff + 1'b1;
                     rowbase_in = rowbase_ff + AW'(tcw_pkg::COLUMNS);
                     st_in = S_DONE;
                  end
               end
               tcw_pkg::OP_RETURN: begin col_in = 7'd0; st_in = S_DONE; end
               tcw_pkg::OP_BACK: begin
                  if (col_ff != 7'd0) col_in = col_ff - 1'b1;
                  else if (row_ff != 5'd0) begin
                     col_in = 7'(tcw_pkg::COLUMNS - 1); row_in = row_ff - 1'b1;
                     rowbase_in = rowbase_ff - AW'(tcw_pkg::COLUMNS);
                  end
                  st_in = S_DONE;
               end
               tcw_pkg::OP_CLEAR: begin
                  ptr_in = '0; end_in = LAST; st_in = S_FILL;
               end
               tcw_pkg::OP_SETCUR: begin
                  col_in = cmd_ff.col; row_in = cmd_ff.row;
                  rowbase_in = AW'(cmd_ff.row) * AW'(tcw_pkg::COLUMNS);
                  st_in = S_DONE;
               end
               default: begin
                  re = 1'b1;
                  raddr = AW'(cmd_ff.row) * AW'(tcw_pkg::COLUMNS) + AW'(cmd_ff.col);
                  st_in = S_RDWT;
               end
            endcase
         end
         // scroll: read cell ptr+COLUMNS, then write it to ptr
         S_SCRD: begin
            if (ptr_ff == SHIFT_END) begin
               end_in = LAST; st_in = S_FILL;
            end else begin
               re = 1'b1; raddr = ptr_ff + AW'(tcw_pkg::COLUMNS); st_in = S_SCWR;
            end
         end
         S_SCWR: begin
            we = 1'b1; wdata = rdata_ff; ptr_in = ptr_ff + 1'b1; st_in = S_SCRD;
         end
         S_FILL: begin
            we = 1'b1; ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == end_ff) begin
               if (cmd_ff.op == tcw_pkg::OP_PRINT && reps_ff != 3'd0)
                  st_in = S_EXEC;
               else st_in = S_DONE;
            end
         end
         S_RDWT: st_in = S_DONE;
         // wait here while the previous result is still held
         S_DONE: if (!rsp_v_ff || rsp_tready) begin
            rsp_v_in = 1'b1; cap = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   logic [6:0] ocol_ff;
   logic [4:0] orow_ff;
   logic [10:0] oofs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_INIT; col_ff <= '0; row_ff <= '0; rowbase_ff <= '0;
         ptr_ff <= '0; rsp_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in; col_ff <= col_in; row_ff <= row_in;
         rowbase_ff <= rowbase_in; ptr_ff <= ptr_in; rsp_v_ff <= rsp_v_in;
      end
      end_ff <= end_in; reps_ff <= reps_in;
      if (load) begin cmd_ff <= q_cmd; attr_ff <= q_cmd.attr; end
      if (cap) begin
         ocol_ff <= col_ff; orow_ff <= row_ff;
         oofs_ff <= 11'(rowbase_ff + AW'(col_ff));
         cell_ff <= (cmd_ff.op == tcw_pkg::OP_READ) ? rdata_ff : 16'd0;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = {1'b0, cell_ff[15:8], cell_ff[7:0], oofs_ff, orow_ff, ocol_ff};
endmodule
